FILE: design/stable_priority_sorter_defines.svh
// ----------------------------------------------------------------------------
// Stable priority sorter assertion macros
// Shared property wrappers, clocked on clk_i and quiet while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_SORTER_DEFINES_SVH
`define STABLE_PRIORITY_SORTER_DEFINES_SVH

// Same-cycle implication
`define SPS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/spsort_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority sorter package
// Types, codes and constants shared by the sorter cells and the top level.
// ----------------------------------------------------------------------------
package spsort_pkg;

  // Default capacity of the cell row
  localparam int unsigned MAX_TASKS_DEF = 32;

  // Field widths
  localparam int unsigned TAG_W      = 16;
  localparam int unsigned PRIO_W     = 16;
  localparam int unsigned ARR_W      = 5;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic signed [PRIO_W-1:0] DEFAULT_PRIO_RST = 16'sd5;

  // Sort mode codes; the unused code sorts descending
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ASC    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DESC   = 2'd2;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SORT_MODE    = 2'd0,
    CFG_DEFAULT_PRIO = 2'd1
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SORT,
    ST_EMIT
  } state_e;

  // One stored task
  typedef struct packed {
    logic signed [PRIO_W-1:0] prio;
    logic [TAG_W-1:0]         tag;
    logic [ARR_W-1:0]         arrival;
  } entry_t;

  // Row-wide control from the sequencer
  typedef struct packed {
    logic              load;    // write the new task into the cell at the fill point
    logic              shift;   // move every entry one cell toward the head
    logic              sort;    // run one compare-exchange pass
    logic              parity;  // pair cells starting at even or odd index
    logic [MODE_W-1:0] mode;
  } ctrl_t;

endpackage

FILE: design/spsort_cell.sv
// ----------------------------------------------------------------------------
// Stable priority sorter cell
// Holds one task and exchanges it with its neighbors: load, shift toward
// the head, or compare-exchange with the next cell during a sort pass.
// ----------------------------------------------------------------------------
module spsort_cell #(
  parameter int unsigned MaxTasks = spsort_pkg::MAX_TASKS_DEF,
  parameter int unsigned Idx      = 0,
  parameter int unsigned CntW     = $clog2(MaxTasks + 1)
) (
  input  logic                clk_i,
  input  spsort_pkg::ctrl_t   ctrl_i,
  input  logic [CntW-1:0]     count_i,
  input  spsort_pkg::entry_t  new_i,
  input  spsort_pkg::entry_t  prev_i,
  input  logic                prev_swap_i,
  input  spsort_pkg::entry_t  next_i,
  output spsort_pkg::entry_t  entry_o,
  output logic                swap_o
);
  import spsort_pkg::*;

  localparam logic [CntW-1:0] IdxV  = CntW'(Idx);
  localparam logic [CntW-1:0] NextV = CntW'(Idx + 1);
  localparam logic            IdxOdd = 1'(Idx % 2);

  entry_t entry_q, entry_d;
  logic   pair_act;
  logic   out_of_order;

  // Strict compare keeps equal priorities in arrival order
  always_comb begin
    unique case (ctrl_i.mode)
      MODE_INSERT: out_of_order = 1'b0;
      MODE_ASC:    out_of_order = entry_q.prio > next_i.prio;
      default:     out_of_order = entry_q.prio < next_i.prio;
    endcase
  end

  // This cell leads a pair when parity matches and both cells hold tasks
  assign pair_act = ctrl_i.sort && (ctrl_i.parity == IdxOdd) && (count_i > NextV);
  assign swap_o   = pair_act && out_of_order;

  // Pick the next content
  always_comb begin
    priority if (ctrl_i.load && (count_i == IdxV)) begin
      entry_d = new_i;
    end else if (ctrl_i.shift || swap_o) begin
      entry_d = next_i;
    end else if (prev_swap_i) begin
      entry_d = prev_i;
    end else begin
      entry_d = entry_q;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: design/stable_priority_sorter.sv
// ----------------------------------------------------------------------------
// Stable priority sorter
// Collects a set of tasks, orders them by priority in a row of cells with
// stable odd-even compare-exchange passes, and emits the tags in order.
// ----------------------------------------------------------------------------
//   channel | signals                                     | direction
//   --------+---------------------------------------------+----------
//   in      | in_valid_i/in_ready_o, task fields           | to block
//   out     | out_valid_o/out_ready_i, result fields       | from block
//   cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, data   | to block
//
// Loading takes one task beat per cycle. After the beat marked last, the row
// runs n compare-exchange passes (n tasks held, one pass per cycle), then
// shifts out one result per cycle while out_ready_i is high.
// Input is held off during the passes and the emission. Reset empties the
// row and restores the registers; cell contents are not cleared.
// A stalled output beat holds the row; configuration is always taken.
// ----------------------------------------------------------------------------
`include "stable_priority_sorter_defines.svh"

module stable_priority_sorter #(
  parameter int unsigned MaxTasks = spsort_pkg::MAX_TASKS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // task input
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [spsort_pkg::TAG_W-1:0]          task_tag_i,
  input  logic signed [spsort_pkg::PRIO_W-1:0]  priority_req_i,
  input  logic                                  priority_given_i,
  input  logic                                  last_task_i,
  // result output
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [spsort_pkg::TAG_W-1:0]          sorted_tag_o,
  output logic [spsort_pkg::ARR_W-1:0]          arrival_index_o,
  output logic                                  end_of_set_o,
  output logic                                  overflow_o,
  // configuration writes
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [spsort_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [spsort_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import spsort_pkg::*;

  localparam int unsigned     CntW      = $clog2(MaxTasks + 1);
  localparam logic [CntW-1:0] MaxTasksV = CntW'(MaxTasks);
  localparam logic [CntW-1:0] OneV      = CntW'(1);

  state_e                    state_q, state_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [CntW-1:0]           pass_q, pass_d;
  logic                      dropped_q, dropped_d;
  logic [MODE_W-1:0]         sort_mode_q;
  logic signed [PRIO_W-1:0]  default_prio_q;
  ctrl_t                     ctrl;
  entry_t                    new_entry;
  entry_t                    ent [MaxTasks];
  logic                      swp [MaxTasks];

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sort_mode_q    <= MODE_ASC;
      default_prio_q <= DEFAULT_PRIO_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SORT_MODE:    sort_mode_q    <= cfg_data_i[MODE_W-1:0];
        CFG_DEFAULT_PRIO: default_prio_q <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // Build the incoming entry
  assign new_entry.prio    = priority_given_i ? priority_req_i : default_prio_q;
  assign new_entry.tag     = task_tag_i;
  assign new_entry.arrival = ARR_W'(count_q);

  // Sequencer registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      pass_q    <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      pass_q    <= pass_d;
      dropped_q <= dropped_d;
    end
  end

  // Next state and row control
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    pass_d      = pass_q;
    dropped_d   = dropped_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    ctrl.load   = 1'b0;
    ctrl.shift  = 1'b0;
    ctrl.sort   = 1'b0;
    ctrl.parity = pass_q[0];
    ctrl.mode   = sort_mode_q;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (count_q < MaxTasksV) begin
            ctrl.load = 1'b1;
            count_d   = count_q + OneV;
          end else begin
            dropped_d = 1'b1;
          end
          if (last_task_i) begin
            state_d = ST_SORT;
          end
        end
      end
      ST_SORT: begin
        ctrl.sort = 1'b1;
        if (pass_q == count_q - OneV) begin
          pass_d  = '0;
          state_d = ST_EMIT;
        end else begin
          pass_d = pass_q + OneV;
        end
      end
      ST_EMIT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          ctrl.shift = 1'b1;
          count_d    = count_q - OneV;
          if (count_q == OneV) begin
            dropped_d = 1'b0;
            state_d   = ST_LOAD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Row of cells
  for (genvar g = 0; g < MaxTasks; g++) begin : g_cell
    entry_t prev_ent;
    entry_t next_ent;
    logic   prev_swp;

    if (g == 0) begin : g_head
      assign prev_ent = '0;
      assign prev_swp = 1'b0;
    end else begin : g_mid
      assign prev_ent = ent[g-1];
      assign prev_swp = swp[g-1];
    end

    if (g == MaxTasks - 1) begin : g_tail
      assign next_ent = '0;
    end else begin : g_body
      assign next_ent = ent[g+1];
    end

    spsort_cell #(
      .MaxTasks (MaxTasks),
      .Idx      (g),
      .CntW     (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .new_i       (new_entry),
      .prev_i      (prev_ent),
      .prev_swap_i (prev_swp),
      .next_i      (next_ent),
      .entry_o     (ent[g]),
      .swap_o      (swp[g])
    );
  end

  // Head cell drives the result beat
  assign sorted_tag_o    = ent[0].tag;
  assign arrival_index_o = ent[0].arrival;
  assign end_of_set_o    = (count_q == OneV);
  assign overflow_o      = dropped_q;

  // Checks
  `SPS_ASSERT_NOW(a_no_load_while_emit, out_valid_o, !in_ready_o, "input open during emission")
  `SPS_ASSERT_NEXT(a_last_closes, in_valid_i && in_ready_o && last_task_i, !in_ready_o,
                   "input still open after last task")
  `SPS_ASSERT_NEXT(a_set_ends, out_valid_o && out_ready_i && end_of_set_o, !out_valid_o,
                   "results continue past end of set")
  `SPS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= MaxTasksV, "task count beyond capacity")

endmodule

FILE: tb/tb_stable_priority_sorter.sv
// ----------------------------------------------------------------------------
// Stable priority sorter testbench
// Drives task sets through the sorter under every sort mode and several
// default priorities. An in-bench predictor builds the ordered result list
// for each closed set, and the monitor checks every result beat against it.
// Both channels idle at random, and the register writes happen only while the
// sorter is drained.
// ----------------------------------------------------------------------------
module tb_stable_priority_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  import spsort_pkg::*;

  localparam int unsigned CAPACITY     = MAX_TASKS_DEF;
  localparam int unsigned TARGET_BEATS = 420;
  localparam int unsigned IDLE_PCT     = 6;
  localparam int unsigned DRAIN_CYCLES = 8;

  // Mode code with no meaning of its own; it sorts descending
  localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
  // Register indexes past the end of the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic [TAG_W-1:0]         tag;
    logic signed [PRIO_W-1:0] prio;
    logic                     given;
    logic                     last;
  } task_beat_t;

  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [ARR_W-1:0] arrival;
    logic             eos;
    logic             ovf;
  } order_beat_t;

  logic                     clk_i            = 1'b0;
  logic                     rst_ni           = 1'b0;
  logic                     in_valid_i       = 1'b0;
  logic                     in_ready_o;
  logic [TAG_W-1:0]         task_tag_i       = '0;
  logic signed [PRIO_W-1:0] priority_req_i   = '0;
  logic                     priority_given_i = 1'b0;
  logic                     last_task_i      = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i      = 1'b0;
  logic [TAG_W-1:0]         sorted_tag_o;
  logic [ARR_W-1:0]         arrival_index_o;
  logic                     end_of_set_o;
  logic                     overflow_o;
  logic                     cfg_valid_i      = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i      = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i       = '0;

  stable_priority_sorter #(
    .MaxTasks(CAPACITY)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .task_tag_i      (task_tag_i),
    .priority_req_i  (priority_req_i),
    .priority_given_i(priority_given_i),
    .last_task_i     (last_task_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .sorted_tag_o    (sorted_tag_o),
    .arrival_index_o (arrival_index_o),
    .end_of_set_o    (end_of_set_o),
    .overflow_o      (overflow_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Quiet windows: neither side idles while idle_ok is low, at the start of each cyc period
  int unsigned cyc = 0;
  logic        idle_ok;
  always @(posedge clk_i) cyc <= cyc + 1;
  assign idle_ok = (cyc % 3000) >= 800;

  // ---------------------------------------------------------------------------
  // Predictor state: register copies, the held set and the expected order
  // ---------------------------------------------------------------------------
  logic [MODE_W-1:0]        mode_q      = MODE_ASC;
  logic signed [PRIO_W-1:0] dflt_prio_q = DEFAULT_PRIO_RST;
  logic [TAG_W-1:0]         held_tag  [CAPACITY];
  logic signed [PRIO_W-1:0] held_prio [CAPACITY];
  int unsigned              held_count   = 0;
  bit                       held_dropped = 1'b0;
  order_beat_t              order_q [$];
  task_beat_t               task_fifo [$];

  int unsigned beats_sent    = 0;
  int unsigned sets_closed   = 0;
  int unsigned sets_overflow = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned sets_by_mode [4] = '{default: 0};

  // True when entry a has to follow entry b under the current mode
  function automatic bit ranks_later(int unsigned a, int unsigned b);
    if (mode_q == MODE_INSERT) return 1'b0;
    if (mode_q == MODE_ASC) return held_prio[a] > held_prio[b];
    return held_prio[a] < held_prio[b];
  endfunction

  // Store one task; on the closing beat, order the set and queue its results
  function automatic void absorb_task(task_beat_t t);
    int unsigned rank [CAPACITY];
    int unsigned j;
    order_beat_t ob;
    if (held_count < CAPACITY) begin
      held_tag[held_count]  = t.tag;
      held_prio[held_count] = t.given ? t.prio : dflt_prio_q;
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!t.last) return;
    // stable insertion: only move past strictly later-ranked entries
    for (int unsigned i = 0; i < held_count; i++) begin
      j = i;
      while (j > 0 && ranks_later(rank[j-1], i)) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = i;
    end
    for (int unsigned i = 0; i < held_count; i++) begin
      ob.tag     = held_tag[rank[i]];
      ob.arrival = ARR_W'(rank[i]);
      ob.eos     = (i + 1 == held_count);
      ob.ovf     = held_dropped;
      order_q.insert(order_q.size(), ob);
    end
    sets_closed++;
    if (held_dropped) sets_overflow++;
    sets_by_mode[mode_q]++;
    held_count   = 0;
    held_dropped = 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: present task beats from the queue, predict on each accepted beat
  // ---------------------------------------------------------------------------
  task_beat_t drv_beat;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        absorb_task(task_beat_t'{task_tag_i, priority_req_i, priority_given_i,
                                 last_task_i});
        beats_sent++;
      end
      if (task_fifo.size() != 0 && !(idle_ok && $urandom_range(99) < IDLE_PCT)) begin
        drv_beat = task_fifo.pop_front();
        in_valid_i       <= 1'b1;
        task_tag_i       <= drv_beat.tag;
        priority_req_i   <= drv_beat.prio;
        priority_given_i <= drv_beat.given;
        last_task_i      <= drv_beat.last;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result beat against the oldest expected one
  // ---------------------------------------------------------------------------
  order_beat_t want, got;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got = '{sorted_tag_o, arrival_index_o, end_of_set_o, overflow_o};
        results_seen++;
        if (order_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: result beat with none expected: tag %h arr %0d eos %b ovf %b",
                     $realtime, got.tag, got.arrival, got.eos, got.ovf);
        end else begin
          want = order_q.pop_front();
          if (got.tag !== want.tag || got.arrival !== want.arrival ||
              got.eos !== want.eos || got.ovf !== want.ovf) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%t: result mismatch: expected tag %h arr %0d eos %b ovf %b",
                       $realtime, want.tag, want.arrival, want.eos, want.ovf);
              $display("    got tag %h arr %0d eos %b ovf %b",
                       got.tag, got.arrival, got.eos, got.ovf);
            end
          end
        end
      end
      out_ready_i <= !(idle_ok && $urandom_range(99) < IDLE_PCT);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_SORT_MODE:    mode_q = data[MODE_W-1:0];
      CFG_DEFAULT_PRIO: dflt_prio_q = data;
      default: ;
    endcase
  endtask

  // Hold until every queued beat went in and every expected result came out
  task automatic wait_drained();
    do @(posedge clk_i);
    while (task_fifo.size() != 0 || in_valid_i || order_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void push_task(logic [TAG_W-1:0] tag, logic signed [PRIO_W-1:0] prio,
                                    logic given, logic last);
    task_fifo.insert(task_fifo.size(), task_beat_t'{tag, prio, given, last});
  endfunction

  // Queue one set of n tasks; span 0 draws priorities over the full range
  function automatic void enqueue_set(int unsigned n, int unsigned span);
    logic signed [PRIO_W-1:0] prio;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        prio = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      else if (span == 0)
        prio = PRIO_W'($urandom);
      else
        prio = PRIO_W'(int'($urandom_range(2 * span)) - int'(span));
      push_task(TAG_W'($urandom), prio, $urandom_range(3) != 0, i + 1 == n);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed sets, then random phases between register writes
  // ---------------------------------------------------------------------------
  int unsigned rand_beats = 0;
  int unsigned phase      = 0;
  int unsigned phase_beats, set_len, pick, span;
  logic [CFG_DATA_W-1:0] dflt_raw;

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // ascending at reset defaults: extreme tags and priorities, ties, defaults
    push_task(16'h0000, 16'sh7FFF, 1'b1, 1'b0);
    push_task(16'hFFFF, 16'sh8000, 1'b1, 1'b0);
    push_task(16'h8000, 16'sd5,    1'b1, 1'b0);
    push_task(16'h7FFF, 16'sd0,    1'b0, 1'b0);
    push_task(16'h5A5A, -16'sd1,   1'b1, 1'b0);
    push_task(16'hA5A5, 16'sh8000, 1'b0, 1'b1);
    // a set of a single task
    push_task(16'h1234, 16'sd100,  1'b1, 1'b1);
    wait_drained();

    // insertion order with the lowest default
    write_reg(CFG_SORT_MODE, CFG_DATA_W'(MODE_INSERT));
    write_reg(CFG_DEFAULT_PRIO, 16'h8000);
    push_task(16'h0001, 16'sh7FFF, 1'b1, 1'b0);
    push_task(16'h0002, 16'sh8000, 1'b1, 1'b0);
    push_task(16'h0003, 16'sh7FFF, 1'b0, 1'b0);
    push_task(16'h0004, 16'sd0,    1'b1, 1'b0);
    push_task(16'h0005, -16'sd7,   1'b1, 1'b1);
    wait_drained();

    // descending with the highest default
    write_reg(CFG_SORT_MODE, CFG_DATA_W'(MODE_DESC));
    write_reg(CFG_DEFAULT_PRIO, 16'h7FFF);
    push_task(16'h0011, 16'sd3,    1'b1, 1'b0);
    push_task(16'h0012, 16'sh8000, 1'b0, 1'b0);
    push_task(16'h0013, 16'sh7FFF, 1'b1, 1'b0);
    push_task(16'h0014, 16'sh8000, 1'b1, 1'b0);
    push_task(16'h0015, 16'sd3,    1'b1, 1'b1);
    wait_drained();

    // spare mode code through an all-ones write; writes past the list do nothing
    write_reg(CFG_SORT_MODE, 16'hFFFF);
    write_reg(CFG_DEFAULT_PRIO, 16'h0000);
    write_reg(CFG_SPARE_A, 16'hFFFF);
    write_reg(CFG_SPARE_B, 16'h5555);
    push_task(16'h0021, -16'sd2,   1'b1, 1'b0);
    push_task(16'h0022, 16'sd0,    1'b0, 1'b0);
    push_task(16'h0023, 16'sd9,    1'b1, 1'b0);
    push_task(16'h0024, 16'sd0,    1'b1, 1'b0);
    push_task(16'h0025, 16'sd9,    1'b1, 1'b1);
    wait_drained();

    // random phases, each under a new register setting
    while (rand_beats < TARGET_BEATS) begin
      pick = $urandom_range(5);
      case (pick)
        0:       dflt_raw = 16'h8000;
        1:       dflt_raw = 16'h7FFF;
        2:       dflt_raw = 16'h0000;
        3:       dflt_raw = CFG_DATA_W'(int'($urandom_range(8)) - 4);
        default: dflt_raw = CFG_DATA_W'($urandom);
      endcase
      write_reg(CFG_SORT_MODE, CFG_DATA_W'($urandom));
      write_reg(CFG_DEFAULT_PRIO, dflt_raw);
      if ($urandom_range(3) == 0)
        write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));

      phase_beats = 0;
      // first phase fills the row exactly, then overfills it
      if (phase == 0) begin
        enqueue_set(CAPACITY, 4);
        enqueue_set(CAPACITY + 4, 1000);
        phase_beats = 2 * CAPACITY + 4;
      end
      while (phase_beats < 50 + $urandom_range(40)) begin
        pick = $urandom_range(99);
        if (pick < 70)      set_len = $urandom_range(8, 1);
        else if (pick < 85) set_len = $urandom_range(CAPACITY - 1, 9);
        else if (pick < 93) set_len = CAPACITY;
        else                set_len = $urandom_range(CAPACITY + 8, CAPACITY + 1);
        pick = $urandom_range(9);
        span = (pick < 5) ? 4 : (pick < 8) ? 1000 : 0;
        enqueue_set(set_len, span);
        phase_beats += set_len;
      end
      rand_beats += phase_beats;
      phase++;
      wait_drained();
    end

    $display("Run covered %0d task beats in %0d sets (%0d overflowed), %0d result beats checked.",
             beats_sent, sets_closed, sets_overflow, results_seen);
    $display("Sets per mode: insertion %0d, ascending %0d, descending %0d, spare code %0d.",
             sets_by_mode[MODE_INSERT], sets_by_mode[MODE_ASC],
             sets_by_mode[MODE_DESC], sets_by_mode[MODE_SPARE]);
    if (order_q.size() != 0)
      $display("%0d expected result beats never arrived", order_q.size());
    if (mismatches == 0 && order_q.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Timeout with %0d beats queued and %0d results expected",
             task_fifo.size(), order_q.size());
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/spsort_pkg.sv
design/spsort_cell.sv
design/stable_priority_sorter.sv
tb/tb_stable_priority_sorter.sv
